// ===== sv/pfa_pkg.sv =====
// shared types and constants for the page frame allocator with reference counts
// no dependencies; imported by pfa_addr_check and page_frame_allocator_refcount_unit
package pfa_pkg;

    // configuration register, result and port widths
    localparam int BASE_W = 20;
    localparam int FIRST_W = 13;
    localparam int POOL_W = 13;
    localparam int FREE_OUT_W = 13;
    localparam int ADDR_W = 32;
    localparam int PADDR_W = 4;

    // request codes
    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE = 2'd2;
    localparam logic [1:0] REQ_SHARE = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_MISALIGNED = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_SHARED = 3'd4;
    localparam logic [2:0] ST_DOUBLE = 3'd5;

    // register index codes (paddr[3:2])
    localparam logic [1:0] RIDX_BASE = 2'd0;
    localparam logic [1:0] RIDX_FIRST = 2'd1;
    localparam logic [1:0] RIDX_POOL = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_EXEC
    } state_t;

    // address check outcome
    typedef struct packed {
        logic misaligned;
        logic out_of_range;
    } addr_chk_t;

endpackage

// ===== sv/pfa_addr_check.sv =====
// alignment and range check of a page address against the managed pool
// depends on pfa_pkg
module pfa_addr_check #(
    parameter int MAX_PAGES = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic [pfa_pkg::ADDR_W-1:0]          page_addr,
    input  logic [pfa_pkg::BASE_W-1:0]          base_page,
    input  logic [$clog2(MAX_PAGES+1)-1:0]      eff_first,
    input  logic [$clog2(MAX_PAGES+1)-1:0]      eff_pool,
    output pfa_pkg::addr_chk_t                  chk,
    output logic [$clog2(MAX_PAGES)-1:0]        idx
);
    import pfa_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int PFN_W = ADDR_W - PAGE_SHIFT;
    localparam int SUM_W = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;
    localparam int CMP_W = (SUM_W > PFN_W) ? SUM_W : PFN_W;

    logic [PFN_W-1:0] pfn;
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
    logic [CMP_W-1:0] pfn_ext;
    logic [CMP_W-1:0] offset;

    // frame number and pool bounds
    assign pfn = page_addr[ADDR_W-1:PAGE_SHIFT];
    assign pfn_ext = CMP_W'(pfn);
    assign lo = CMP_W'(base_page) + CMP_W'(eff_first);
    assign hi = CMP_W'(base_page) + CMP_W'(eff_pool);
    assign offset = pfn_ext - CMP_W'(base_page);

    // flags and index within the pool
    assign chk.misaligned = (page_addr[PAGE_SHIFT-1:0] != '0);
    assign chk.out_of_range = (pfn_ext < lo) || (pfn_ext >= hi);
    assign idx = offset[IDX_W-1:0];

endmodule

// ===== sv/page_frame_allocator_refcount_unit.sv =====
// top level of the page frame allocator: free queue and reference count memories
// depends on pfa_pkg and pfa_addr_check
//
// Page frame allocator with a FIFO free queue and per-page reference counts, both
// held in single-port-write synchronous memories. Allocate, free and share each read the
// count or queue memory when the request is accepted, then modify, write back and
// register the result once the output register is free. Init sweeps the pool one page per
// clock through the count and queue memories. One request is in flight at a time; a new
// request is taken while the last result still waits in the output register. Configuration
// registers are written over the APB port at byte addresses 0 (base_page), 4 (first_free_index),
// 8 (pool_pages) and should only change while no request is pending.
module page_frame_allocator_refcount_unit #(
    parameter int MAX_PAGES = 4096,
    parameter int COUNT_BITS = 16,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         req_type,
    input  logic [pfa_pkg::ADDR_W-1:0]         page_addr,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pfa_pkg::ADDR_W-1:0]         result_addr,
    output logic [2:0]                         status,
    output logic [pfa_pkg::FREE_OUT_W-1:0]     free_pages,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pfa_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import pfa_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int NW = (CNT_W > POOL_W) ? CNT_W : POOL_W;
    localparam int SUM_W = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;

    // configuration registers
    logic [BASE_W-1:0]  base_reg;
    logic [FIRST_W-1:0] first_reg;
    logic [POOL_W-1:0]  pool_reg;

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_reg;
    logic [IDX_W-1:0]   tail_next;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic [IDX_W-1:0]   ctr_reg;
    logic               out_valid_reg;

    // request payload
    logic [1:0]         req_reg;
    addr_chk_t          chk_reg;
    logic [IDX_W-1:0]   idx_reg;

    // result payload
    logic [ADDR_W-1:0]     res_addr_reg;
    logic [ADDR_W-1:0]     res_addr_next;
    logic [2:0]            status_reg;
    logic [2:0]            status_next;
    logic [FREE_OUT_W-1:0] free_reg;

    // memories and read data
    logic [COUNT_BITS-1:0] cnt_mem [MAX_PAGES];
    logic [IDX_W-1:0]      q_mem [MAX_PAGES];
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [IDX_W-1:0]      q_rd_reg;

    // memory write ports
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_wa;
    logic [COUNT_BITS-1:0] cnt_wd;
    logic                  q_we;
    logic [IDX_W-1:0]      q_wa;
    logic [IDX_W-1:0]      q_wd;

    // misc
    logic [CNT_W-1:0]      eff_pool;
    logic [CNT_W-1:0]      eff_first;
    logic [CNT_W-1:0]      init_free;
    addr_chk_t             chk;
    logic [IDX_W-1:0]      chk_idx;
    logic                  in_fire;
    logic                  exec_done;
    logic                  init_last;
    logic                  cfg_wr;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [SUM_W-1:0]      page_sum;
    logic [CNT_W-1:0]      ctr_ext;

    // effective pool bounds
    assign eff_pool = (NW'(pool_reg) > NW'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(pool_reg);
    assign eff_first = (NW'(first_reg) > NW'(eff_pool)) ? eff_pool : CNT_W'(first_reg);
    assign init_free = eff_pool - eff_first;

    pfa_addr_check #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_addr_check (
        .page_addr (page_addr),
        .base_page (base_reg),
        .eff_first (eff_first),
        .eff_pool  (eff_pool),
        .chk       (chk),
        .idx       (chk_idx)
    );

    // handshakes
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign exec_done = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign ctr_ext = CNT_W'(ctr_reg);
    assign init_last = (ctr_ext == eff_pool - CNT_W'(1));

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_W'(256);
            first_reg <= '0;
            pool_reg <= POOL_W'(4096);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                RIDX_BASE:  base_reg <= pwdata[BASE_W-1:0];
                RIDX_FIRST: first_reg <= pwdata[FIRST_W-1:0];
                RIDX_POOL:  pool_reg <= pwdata[POOL_W-1:0];
                default:    ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[3:2])
            RIDX_BASE:  prdata = 32'(base_reg);
            RIDX_FIRST: prdata = 32'(first_reg);
            RIDX_POOL:  prdata = 32'(pool_reg);
            default:    prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == REQ_INIT && eff_pool != '0)
                        state_next = S_INIT;
                    else
                        state_next = S_EXEC;
                end
            end
            S_INIT:
            begin
                if (init_last)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_done)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // read-modify-write datapath and queue pointers
    assign cnt_dec = cnt_rd_reg - COUNT_BITS'(1);
    assign page_sum = SUM_W'(base_reg) + SUM_W'(q_rd_reg);

    always_comb
    begin
        cnt_we = 1'b0;
        cnt_wa = idx_reg;
        cnt_wd = '0;
        q_we = 1'b0;
        q_wa = tail_reg;
        q_wd = idx_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        total_next = total_reg;
        res_addr_next = '0;
        status_next = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                // init resets the queue pointers up front
                if (in_fire && req_type == REQ_INIT)
                begin
                    head_next = '0;
                    tail_next = (init_free == CNT_W'(MAX_PAGES)) ? '0 : IDX_W'(init_free);
                    total_next = init_free;
                end
            end
            S_INIT:
            begin
                // one page per cycle: reserved get count 1, the rest are queued
                cnt_we = 1'b1;
                cnt_wa = ctr_reg;
                cnt_wd = (ctr_ext < eff_first) ? COUNT_BITS'(1) : '0;
                q_we = (ctr_ext >= eff_first);
                q_wa = IDX_W'(ctr_ext - eff_first);
                q_wd = ctr_reg;
            end
            S_EXEC:
            begin
                case (req_reg)
                    REQ_INIT: status_next = ST_OK;
                    REQ_ALLOC:
                    begin
                        if (total_reg == '0)
                            status_next = ST_EMPTY;
                        else
                        begin
                            cnt_we = exec_done;
                            cnt_wa = q_rd_reg;
                            cnt_wd = COUNT_BITS'(1);
                            head_next = (CNT_W'(head_reg) + CNT_W'(1) >= CNT_W'(MAX_PAGES))
                                ? '0 : head_reg + IDX_W'(1);
                            total_next = total_reg - CNT_W'(1);
                            res_addr_next = ADDR_W'({page_sum, {PAGE_SHIFT{1'b0}}});
                        end
                    end
                    default:
                    begin
                        // free and share
                        if (chk_reg.misaligned)
                            status_next = ST_MISALIGNED;
                        else if (chk_reg.out_of_range)
                            status_next = ST_RANGE;
                        else if (cnt_rd_reg == '0)
                            status_next = ST_DOUBLE;
                        else if (req_reg == REQ_FREE)
                        begin
                            cnt_we = exec_done;
                            cnt_wd = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                if (total_reg < CNT_W'(MAX_PAGES))
                                begin
                                    q_we = exec_done;
                                    tail_next = (CNT_W'(tail_reg) + CNT_W'(1)
                                        >= CNT_W'(MAX_PAGES)) ? '0 : tail_reg + IDX_W'(1);
                                    total_next = total_reg + CNT_W'(1);
                                end
                            end
                            else
                                status_next = ST_SHARED;
                        end
                        else
                        begin
                            // share saturates at the count maximum
                            cnt_we = exec_done && (cnt_rd_reg != '1);
                            cnt_wd = cnt_rd_reg + COUNT_BITS'(1);
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            total_reg <= '0;
            ctr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire || exec_done)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                total_reg <= total_next;
            end
            if (in_fire)
                ctr_reg <= '0;
            else if (state_reg == S_INIT)
                ctr_reg <= ctr_reg + IDX_W'(1);
            if (exec_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_type;
            chk_reg <= chk;
            idx_reg <= chk_idx;
        end
        if (exec_done)
        begin
            res_addr_reg <= res_addr_next;
            status_reg <= status_next;
            free_reg <= FREE_OUT_W'(total_next);
        end
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        if (in_fire)
            cnt_rd_reg <= cnt_mem[chk_idx];
    end

    // free queue memory
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_wa] <= q_wd;
        if (in_fire)
            q_rd_reg <= q_mem[head_reg];
    end

    assign out_valid = out_valid_reg;
    assign result_addr = res_addr_reg;
    assign status = status_reg;
    assign free_pages = free_reg;

endmodule
